// ===== design/gkas_pkg.sv =====
// ---------------------------------------------------------------------------
// gkas_pkg
// Shared sizes, codes and types of the keypoint grid area search block.
// ---------------------------------------------------------------------------
package gkas_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 48;
  localparam int MAX_HITS   = 64;
  localparam int NCELLS     = GRID_COLS * GRID_ROWS;

  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CELL_W     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int HIT_W      = $clog2(MAX_HITS + 1);

  localparam int POS_W      = 20;
  localparam int INV_W      = 16;
  localparam int RAD_W      = 16;
  localparam int LVL_W      = 3;
  localparam int MAXL_W     = 4;
  localparam int OP_W       = 2;
  localparam int ST_W       = 3;
  localparam int OIDX_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_W_INV = 2'd2,
    REG_H_INV = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [LVL_W-1:0]        lvl;
  } point_t;

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
  } cell_t;

endpackage

// ===== design/gkas_if.sv =====
// ---------------------------------------------------------------------------
// gkas_in_if / gkas_out_if
// Valid/ready channels for request beats and result beats.
// ---------------------------------------------------------------------------
interface gkas_in_if import gkas_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [LVL_W-1:0]         point_level;
  logic [RAD_W-1:0]         radius;
  logic [LVL_W-1:0]         min_level;
  logic signed [MAXL_W-1:0] max_level;

  modport source(output valid, op, pos_x, pos_y, point_level, radius, min_level,
                 max_level, input ready);
  modport sink(input valid, op, pos_x, pos_y, point_level, radius, min_level,
               max_level, output ready);
endinterface

interface gkas_out_if import gkas_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [OIDX_W-1:0] point_index;
  logic              last;
  logic              truncated;

  modport source(output valid, status, point_index, last, truncated, input ready);
  modport sink(input valid, status, point_index, last, truncated, output ready);
endinterface

// ===== design/grid_keypoint_area_search.sv =====
// ---------------------------------------------------------------------------
// grid_keypoint_area_search
// Keypoint store with a uniform grid index and a rectangular area query.
// ---------------------------------------------------------------------------
// Request beats arrive on item_i and result beats leave on res_o, both
// valid/ready. The configuration port writes the grid origin and inverse cell
// sizes; the user must write them only while the block is idle, which the
// block does not enforce. One request is worked at a time; a new one is taken
// as soon as the sequencer is back in idle, even while the last result beat
// still waits in the output register. An insert makes two passes through the
// shared multiplier and a read-modify-write of the cell memory. A query runs
// its range setup through the same multiplier, then reads each visited cell
// and each listed point in turn, as every cell and point access is a synchronous
// memory read. A clear, and also the release of reset, runs a clearing pass over
// all 3072 cells of the cell memory; no request is taken during it. A clear then
// returns one beat. A stalled receiver holds the walk when a hit is found while
// one hit is held back and the output register still holds a beat that was not taken.
// ---------------------------------------------------------------------------
module grid_keypoint_area_search import gkas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gkas_in_if.sink               item_i,
  gkas_out_if.source            res_o
);

  localparam int D_W = POS_W + 1;
  localparam int A_W = POS_W + 2;
  localparam int P_W = A_W + INV_W + 1;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_MUL    = 12'b000000000100,
    S_CVT    = 12'b000000001000,
    S_INS    = 12'b000000010000,
    S_IWAIT  = 12'b000000100000,
    S_QSTART = 12'b000001000000,
    S_CELL   = 12'b000010000000,
    S_CWAIT  = 12'b000100000000,
    S_PT     = 12'b001000000000,
    S_PWAIT  = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_e;

  point_t           pt_mem   [MAX_POINTS];
  logic [IDX_W-1:0] nxt_mem  [MAX_POINTS];
  cell_t            cell_mem [NCELLS];

  point_t           pt_rd_q;
  logic [IDX_W-1:0] nxt_rd_q;
  cell_t            cell_rd_q;

  state_e state_q, state_d;
  logic   is_query_q, is_query_d;
  logic   clr_emit_q, clr_emit_d;
  logic [CELL_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic signed [POS_W-1:0] min_x_q, min_y_q;
  logic [INV_W-1:0]        w_inv_q, h_inv_q;

  logic signed [POS_W-1:0]  px_q, px_d, py_q, py_d;
  logic [RAD_W-1:0]         r_q, r_d;
  logic [LVL_W-1:0]         minl_q, minl_d;
  logic signed [MAXL_W-1:0] maxl_q, maxl_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic [1:0]              mstep_q, mstep_d;
  logic signed [P_W-1:0]   prod_q, prod_d;
  logic [COL_W-1:0]        cx_q, cx_d, x0_q, x0_d, x1_q, x1_d, ix_q, ix_d;
  logic [ROW_W-1:0]        cy_q, cy_d, y0_q, y0_d, y1_q, y1_d, iy_q, iy_d;
  logic                    okx_q, okx_d, oky_q, oky_d, empty_q, empty_d;
  logic [CELL_W-1:0]       caddr_q, caddr_d;
  logic [IDX_W-1:0]        cur_q, cur_d, tail_q, tail_d;

  logic                    hold_v_q, hold_v_d, more_q, more_d;
  logic [IDX_W-1:0]        hold_idx_q, hold_idx_d;
  logic [HIT_W-1:0]        hits_q, hits_d;
  status_e                 res_st_q, res_st_d;
  logic [IDX_W-1:0]        res_idx_q, res_idx_d;

  logic                    ov_q, ov_d, o_last_q, o_last_d, o_tr_q, o_tr_d;
  status_e                 o_st_q, o_st_d;
  logic [IDX_W-1:0]        o_idx_q, o_idx_d;

  logic                    in_acc, out_free;
  logic                    pt_we, nxt_we, cell_we, cell_re, pt_re;
  point_t                  pt_wdata;
  logic [IDX_W-1:0]        pt_waddr, nxt_waddr, nxt_wdata;
  cell_t                   cell_wdata;
  logic [CELL_W-1:0]       cell_waddr, cell_raddr, walk_addr, ins_addr;

  logic signed [D_W-1:0]   dxb, dyb, base;
  logic signed [A_W-1:0]   a_op;
  logic [INV_W-1:0]        b_op;
  logic                    axis;
  logic                    neg;
  logic [P_W-1:0]          mag, rq;
  logic signed [P_W-1:0]   fl;
  logic signed [P_W:0]     ce_sum, ce;
  logic signed [D_W-1:0]   hdx, hdy;
  logic [D_W-1:0]          adx, ady;
  logic                    match;

  assign in_acc   = item_i.valid && item_i.ready;
  assign out_free = !ov_q || res_o.ready;
  assign item_i.ready = (state_q == S_IDLE);

  assign res_o.valid       = ov_q;
  assign res_o.status      = o_st_q;
  assign res_o.point_index = OIDX_W'(o_idx_q);
  assign res_o.last        = o_last_q;
  assign res_o.truncated   = o_tr_q;

  // Multiplier operands and product conversions.
  assign dxb  = D_W'(px_q) - D_W'(min_x_q);
  assign dyb  = D_W'(py_q) - D_W'(min_y_q);
  assign axis = is_query_q ? mstep_q[1] : mstep_q[0];
  assign base = axis ? dyb : dxb;
  assign b_op = axis ? h_inv_q : w_inv_q;

  always_comb begin
    a_op = A_W'(base);
    if (is_query_q) begin
      if (mstep_q[0]) begin
        a_op = A_W'(base) + $signed(A_W'(r_q));
      end else begin
        a_op = A_W'(base) - $signed(A_W'(r_q));
      end
    end
  end

  assign prod_d = a_op * $signed({1'b0, b_op});
  assign neg    = prod_q[P_W-1];
  assign mag    = neg ? P_W'(-prod_q) : P_W'(prod_q);
  assign rq     = (mag + P_W'(32768)) >> 16;
  assign fl     = prod_q >>> 16;
  assign ce_sum = {prod_q[P_W-1], prod_q} + $signed((P_W + 1)'(65535));
  assign ce     = ce_sum >>> 16;

  assign walk_addr = CELL_W'(ix_q) * CELL_W'(GRID_ROWS) + CELL_W'(iy_q);
  assign ins_addr  = CELL_W'(cx_q) * CELL_W'(GRID_ROWS) + CELL_W'(cy_q);

  // Hit test against the point just read.
  assign hdx = D_W'(pt_rd_q.x) - D_W'(px_q);
  assign hdy = D_W'(pt_rd_q.y) - D_W'(py_q);
  assign adx = hdx[D_W-1] ? D_W'(-hdx) : D_W'(hdx);
  assign ady = hdy[D_W-1] ? D_W'(-hdy) : D_W'(hdy);
  assign match = (pt_rd_q.lvl >= minl_q)
              && (maxl_q[MAXL_W-1] || (MAXL_W'(pt_rd_q.lvl) <= maxl_q[MAXL_W-1:0]))
              && (adx < D_W'(r_q)) && (ady < D_W'(r_q));

  always_comb begin
    state_d    = state_q;
    is_query_d = is_query_q;
    clr_emit_d = clr_emit_q;
    clr_cnt_d  = clr_cnt_q;
    cnt_d      = cnt_q;
    px_d = px_q;  py_d = py_q;  r_d = r_q;  minl_d = minl_q;  maxl_d = maxl_q;
    idx_d      = idx_q;
    mstep_d    = mstep_q;
    cx_d = cx_q;  cy_d = cy_q;  okx_d = okx_q;  oky_d = oky_q;
    x0_d = x0_q;  x1_d = x1_q;  y0_d = y0_q;  y1_d = y1_q;  empty_d = empty_q;
    ix_d = ix_q;  iy_d = iy_q;  cur_d = cur_q;  tail_d = tail_q;
    caddr_d    = caddr_q;
    hold_v_d   = hold_v_q;
    hold_idx_d = hold_idx_q;
    hits_d     = hits_q;
    more_d     = more_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    ov_d       = ov_q && !res_o.ready;
    o_st_d = o_st_q;  o_idx_d = o_idx_q;  o_last_d = o_last_q;  o_tr_d = o_tr_q;
    pt_we      = 1'b0;
    pt_waddr   = cnt_q[IDX_W-1:0];
    pt_wdata   = '{x: item_i.pos_x, y: item_i.pos_y, lvl: item_i.point_level};
    pt_re      = 1'b0;
    nxt_we     = 1'b0;
    nxt_waddr  = cell_rd_q.tail;
    nxt_wdata  = idx_q;
    cell_we    = 1'b0;
    cell_waddr = clr_cnt_q;
    cell_wdata = '{used: 1'b0, head: '0, tail: '0};
    cell_re    = 1'b0;
    cell_raddr = walk_addr;

    unique case (state_q)
      S_CLEAR: begin
        cell_we = 1'b1;
        if (clr_cnt_q == CELL_W'(NCELLS - 1)) begin
          if (clr_emit_q) begin
            res_st_d  = ST_EMPTY;
            res_idx_d = '0;
            state_d   = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          px_d   = item_i.pos_x;
          py_d   = item_i.pos_y;
          r_d    = item_i.radius;
          minl_d = item_i.min_level;
          maxl_d = item_i.max_level;
          mstep_d = '0;
          unique case (op_e'(item_i.op))
            OP_CLEAR: begin
              cnt_d      = '0;
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
              state_d    = S_CLEAR;
            end
            OP_INSERT: begin
              is_query_d = 1'b0;
              if (cnt_q == CNT_W'(MAX_POINTS)) begin
                res_st_d  = ST_FULL;
                res_idx_d = '0;
                state_d   = S_FIN;
              end else begin
                pt_we   = 1'b1;
                idx_d   = cnt_q[IDX_W-1:0];
                cnt_d   = cnt_q + 1'b1;
                state_d = S_MUL;
              end
            end
            OP_QUERY: begin
              is_query_d = 1'b1;
              hits_d     = '0;
              more_d     = 1'b0;
              hold_v_d   = 1'b0;
              empty_d    = 1'b0;
              res_st_d   = ST_EMPTY;
              res_idx_d  = '0;
              state_d    = S_MUL;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        state_d = S_CVT;
      end
      S_CVT: begin
        state_d = S_MUL;
        mstep_d = mstep_q + 1'b1;
        if (!is_query_q) begin
          if (mstep_q[0]) begin
            oky_d   = neg ? (rq == '0) : (rq < P_W'(GRID_ROWS));
            cy_d    = rq[ROW_W-1:0];
            state_d = S_INS;
          end else begin
            okx_d = neg ? (rq == '0) : (rq < P_W'(GRID_COLS));
            cx_d  = rq[COL_W-1:0];
          end
        end else begin
          unique case (mstep_q)
            2'd0: begin
              x0_d = fl[P_W-1] ? '0 : fl[COL_W-1:0];
              if (fl > $signed(P_W'(GRID_COLS - 1))) empty_d = 1'b1;
            end
            2'd1: begin
              x1_d = (ce > $signed((P_W + 1)'(GRID_COLS - 1))) ?
                     COL_W'(GRID_COLS - 1) : ce[COL_W-1:0];
              if (ce[P_W]) empty_d = 1'b1;
            end
            2'd2: begin
              y0_d = fl[P_W-1] ? '0 : fl[ROW_W-1:0];
              if (fl > $signed(P_W'(GRID_ROWS - 1))) empty_d = 1'b1;
            end
            default: begin
              y1_d = (ce > $signed((P_W + 1)'(GRID_ROWS - 1))) ?
                     ROW_W'(GRID_ROWS - 1) : ce[ROW_W-1:0];
              if (ce[P_W]) empty_d = 1'b1;
              state_d = S_QSTART;
            end
          endcase
        end
      end
      S_INS: begin
        res_idx_d = idx_q;
        if (okx_q && oky_q) begin
          cell_re    = 1'b1;
          cell_raddr = ins_addr;
          caddr_d    = ins_addr;
          res_st_d   = ST_INSERTED;
          state_d    = S_IWAIT;
        end else begin
          res_st_d = ST_OUTSIDE;
          state_d  = S_FIN;
        end
      end
      S_IWAIT: begin
        cell_we    = 1'b1;
        cell_waddr = caddr_q;
        if (cell_rd_q.used) begin
          nxt_we     = 1'b1;
          cell_wdata = '{used: 1'b1, head: cell_rd_q.head, tail: idx_q};
        end else begin
          cell_wdata = '{used: 1'b1, head: idx_q, tail: idx_q};
        end
        state_d = S_FIN;
      end
      S_QSTART: begin
        if (empty_q || (x0_q > x1_q) || (y0_q > y1_q)) begin
          state_d = S_FIN;
        end else begin
          ix_d    = x0_q;
          iy_d    = y0_q;
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        cell_re = 1'b1;
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        if (cell_rd_q.used) begin
          cur_d   = cell_rd_q.head;
          tail_d  = cell_rd_q.tail;
          state_d = S_PT;
        end else if (iy_q < y1_q) begin
          iy_d    = iy_q + 1'b1;
          state_d = S_CELL;
        end else if (ix_q < x1_q) begin
          ix_d    = ix_q + 1'b1;
          iy_d    = y0_q;
          state_d = S_CELL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PT: begin
        pt_re   = 1'b1;
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        if (match && (hits_q == HIT_W'(MAX_HITS))) begin
          more_d  = 1'b1;
          state_d = S_FIN;
        end else if (match && hold_v_q && !out_free) begin
          state_d = S_PWAIT;
        end else begin
          if (match) begin
            if (hold_v_q) begin
              ov_d     = 1'b1;
              o_st_d   = ST_HIT;
              o_idx_d  = hold_idx_q;
              o_last_d = 1'b0;
              o_tr_d   = 1'b0;
            end
            hold_v_d   = 1'b1;
            hold_idx_d = cur_q;
            hits_d     = hits_q + 1'b1;
          end
          if (cur_q != tail_q) begin
            cur_d   = nxt_rd_q;
            state_d = S_PT;
          end else if (iy_q < y1_q) begin
            iy_d    = iy_q + 1'b1;
            state_d = S_CELL;
          end else if (ix_q < x1_q) begin
            ix_d    = ix_q + 1'b1;
            iy_d    = y0_q;
            state_d = S_CELL;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_last_d = 1'b1;
          if (hold_v_q) begin
            o_st_d  = ST_HIT;
            o_idx_d = hold_idx_q;
            o_tr_d  = more_q;
          end else begin
            o_st_d  = res_st_q;
            o_idx_d = res_idx_q;
            o_tr_d  = 1'b0;
          end
          hold_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (pt_re) begin
      pt_rd_q  <= pt_mem[cur_q];
      nxt_rd_q <= nxt_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_emit_q <= 1'b0;
      clr_cnt_q  <= '0;
      cnt_q      <= '0;
      hold_v_q   <= 1'b0;
      ov_q       <= 1'b0;
      is_query_q <= 1'b0;
      min_x_q    <= '0;
      min_y_q    <= '0;
      w_inv_q    <= INV_W'(410);
      h_inv_q    <= INV_W'(410);
    end else begin
      state_q    <= state_d;
      clr_emit_q <= clr_emit_d;
      clr_cnt_q  <= clr_cnt_d;
      cnt_q      <= cnt_d;
      hold_v_q   <= hold_v_d;
      ov_q       <= ov_d;
      is_query_q <= is_query_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_MIN_X: min_x_q <= cfg_data_i[POS_W-1:0];
          REG_MIN_Y: min_y_q <= cfg_data_i[POS_W-1:0];
          REG_W_INV: w_inv_q <= cfg_data_i[INV_W-1:0];
          default:   h_inv_q <= cfg_data_i[INV_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  r_q <= r_d;  minl_q <= minl_d;  maxl_q <= maxl_d;
    idx_q      <= idx_d;
    mstep_q    <= mstep_d;
    prod_q     <= prod_d;
    cx_q <= cx_d;  cy_q <= cy_d;  okx_q <= okx_d;  oky_q <= oky_d;
    x0_q <= x0_d;  x1_q <= x1_d;  y0_q <= y0_d;  y1_q <= y1_d;  empty_q <= empty_d;
    ix_q <= ix_d;  iy_q <= iy_d;  cur_q <= cur_d;  tail_q <= tail_d;
    caddr_q    <= caddr_d;
    hold_idx_q <= hold_idx_d;
    hits_q     <= hits_d;
    more_q     <= more_d;
    res_st_q   <= res_st_d;
    res_idx_q  <= res_idx_d;
    o_st_q <= o_st_d;  o_idx_q <= o_idx_d;  o_last_q <= o_last_d;  o_tr_q <= o_tr_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PWAIT) |-> (hits_q <= HIT_W'(MAX_HITS)))
    else $error("hit count exceeds the result limit");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL) |-> ((ix_q <= x1_q) && (iy_q <= y1_q) && (iy_q >= y0_q)))
    else $error("cell walk left the query range");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_free) |=> (ov_q && o_last_q))
    else $error("final beat not loaded");

endmodule

// ===== bench/gkas_test_if.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench channel note
// The channels of the block are the interfaces of the design; this file fixes
// the time unit for the bench and holds the result_t beat type, no further logic.
// ---------------------------------------------------------------------------
package gkas_test_pkg;
  import gkas_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [OIDX_W-1:0] point_index;
    logic              last;
    logic              truncated;
  } result_t;
endpackage

// ===== bench/grid_keypoint_area_search_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Keypoint grid area search testbench
// Drives clear, insert, area query and no-op beats with random idling on both
// sides, predicts every result beat with an independent grid model and compares
// them in order, across several grid origins and inverse cell sizes.
// ---------------------------------------------------------------------------
module grid_keypoint_area_search_test;
  import gkas_pkg::*;
  import gkas_test_pkg::*;

  localparam longint LIMIT = 60000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gkas_in_if item_if ();
  gkas_out_if res_if ();

  grid_keypoint_area_search DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .item_i(item_if.sink), .res_o(res_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic signed [POS_W-1:0] px_mem [MAX_POINTS];
  logic signed [POS_W-1:0] py_mem [MAX_POINTS];
  logic [LVL_W-1:0] pl_mem [MAX_POINTS];
  int pcount;
  int cell_list [NCELLS][$];
  longint min_x, min_y, w_inv, h_inv;
  result_t pending_results [$];
  int errors;
  int send_idle, recv_stall;
  longint cycles;

  function automatic longint rnd16(longint p, int mode);
    longint a;
    a = p < 0 ? -p : p;
    if (mode == 0) a = (a + 32768) >>> 16;
    else if ((mode == 1) == (p >= 0)) a = a >>> 16;
    else a = (a + 65535) >>> 16;
    return p < 0 ? -a : a;
  endfunction

  function automatic result_t mk(status_e st, int idx, bit lst, bit tr);
    result_t r;
    r.status = st;
    r.point_index = idx[OIDX_W-1:0];
    r.last = lst;
    r.truncated = tr;
    return r;
  endfunction

  function automatic void add_expected(result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_grid(op_e op, longint x, longint y, int lvl,
                                       longint r, int minl, int maxl);
    longint cx, cy, x0, x1, y0, y1, dx, dy;
    int n, c, i;
    bit more;
    result_t hits [$];
    case (op)
      OP_CLEAR: begin
        pcount = 0;
        foreach (cell_list[k]) cell_list[k].delete();
        add_expected(mk(ST_EMPTY, 0, 1, 0));
      end
      OP_INSERT: begin
        if (pcount >= MAX_POINTS) begin
          add_expected(mk(ST_FULL, 0, 1, 0));
        end else begin
          i = pcount++;
          px_mem[i] = POS_W'(x);
          py_mem[i] = POS_W'(y);
          pl_mem[i] = LVL_W'(lvl);
          cx = rnd16((x - min_x) * w_inv, 0);
          cy = rnd16((y - min_y) * h_inv, 0);
          if (cx < 0 || cx >= GRID_COLS || cy < 0 || cy >= GRID_ROWS) begin
            add_expected(mk(ST_OUTSIDE, i, 1, 0));
          end else begin
            c = int'(cx * GRID_ROWS + cy);
            cell_list[c] = {cell_list[c], i};
            add_expected(mk(ST_INSERTED, i, 1, 0));
          end
        end
      end
      OP_QUERY: begin
        n = 0;
        more = 0;
        x0 = rnd16((x - min_x - r) * w_inv, 1);
        x1 = rnd16((x - min_x + r) * w_inv, 2);
        y0 = rnd16((y - min_y - r) * h_inv, 1);
        y1 = rnd16((y - min_y + r) * h_inv, 2);
        if (x0 < 0) x0 = 0;
        if (x1 > GRID_COLS - 1) x1 = GRID_COLS - 1;
        if (y0 < 0) y0 = 0;
        if (y1 > GRID_ROWS - 1) y1 = GRID_ROWS - 1;
        for (longint ix = x0; ix <= x1 && !more; ix++) begin
          for (longint iy = y0; iy <= y1 && !more; iy++) begin
            c = int'(ix * GRID_ROWS + iy);
            for (int k = 0; k < cell_list[c].size(); k++) begin
              i = cell_list[c][k];
              dx = px_mem[i] - x;
              dy = py_mem[i] - y;
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              if (!more && pl_mem[i] >= minl && (maxl < 0 || pl_mem[i] <= maxl) &&
                  dx < r && dy < r) begin
                if (n >= MAX_HITS) more = 1;
                else begin
                  hits = {hits, mk(ST_HIT, i, 0, 0)};
                  n++;
                end
              end
            end
          end
        end
        if (n == 0) begin
          add_expected(mk(ST_EMPTY, 0, 1, 0));
        end else begin
          hits[n-1].last = 1;
          hits[n-1].truncated = more;
          foreach (hits[k]) add_expected(hits[k]);
        end
      end
      default: ;
    endcase
  endfunction

  initial begin
    item_if.valid = 1'b0;
    item_if.op = OP_NONE;
    item_if.pos_x = '0;
    item_if.pos_y = '0;
    item_if.point_level = '0;
    item_if.radius = '0;
    item_if.min_level = '0;
    item_if.max_level = '0;
    res_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    result_t got, exp_r;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.status, res_if.point_index, res_if.last, res_if.truncated};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t mismatch: expected st=%0d idx=%0d last=%0b tr=%0b,",
                   $time, exp_r.status, exp_r.point_index, exp_r.last,
                   exp_r.truncated);
          $display("  actual st=%0d idx=%0d last=%0b tr=%0b",
                   got.status, got.point_index, got.last, got.truncated);
          errors++;
        end
      end
    end
  end

  task automatic send_item(op_e op, longint x, longint y, int lvl, int r, int minl,
                           int maxl);
    logic signed [POS_W-1:0] sx, sy;
    logic [LVL_W-1:0] sl, smin;
    logic [RAD_W-1:0] sr;
    logic signed [MAXL_W-1:0] smax;
    sx = POS_W'(x);
    sy = POS_W'(y);
    sl = LVL_W'(lvl);
    sr = RAD_W'(r);
    smin = LVL_W'(minl);
    smax = MAXL_W'(maxl);
    while ($urandom_range(99) < send_idle) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.op <= op;
    item_if.pos_x <= sx;
    item_if.pos_y <= sy;
    item_if.point_level <= sl;
    item_if.radius <= sr;
    item_if.min_level <= smin;
    item_if.max_level <= smax;
    do @(posedge clk_i); while (!item_if.ready);
    predict_grid(op, longint'(sx), longint'(sy), int'(sl), longint'(sr), int'(smin),
                 int'(smax));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3200) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    case (idx)
      REG_MIN_X: min_x = $signed(val[POS_W-1:0]);
      REG_MIN_Y: min_y = $signed(val[POS_W-1:0]);
      REG_W_INV: w_inv = val[INV_W-1:0];
      default:   h_inv = val[INV_W-1:0];
    endcase
  endtask

  task automatic set_grid(longint mx, longint my, longint wi, longint hi);
    drain_results();
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_W_INV, wi);
    write_reg(REG_H_INV, hi);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, 100, 100, 0, 800, 0, -1);
    send_item(OP_INSERT, 0, 0, 0, 0, 0, 0);
    send_item(OP_INSERT, 524287, 524287, 7, 65535, 7, 7);
    send_item(OP_INSERT, -524288, -524288, 5, 0, 0, 0);
    send_item(OP_INSERT, 160, 160, 3, 0, 0, 0);
    send_item(OP_INSERT, 170, 150, 7, 0, 0, 0);
    send_item(OP_NONE, 5, 5, 1, 5, 1, 1);
    send_item(OP_QUERY, 160, 160, 0, 0, 0, -1);
    send_item(OP_QUERY, 160, 160, 0, 65535, 0, -1);
    send_item(OP_QUERY, 160, 160, 4, 200, 4, 7);
    send_item(OP_QUERY, 160, 160, 0, 200, 0, 3);
    send_item(OP_QUERY, -524288, 524287, 2, 65535, 0, -8);
    send_item(OP_QUERY, 524287, -524288, 0, 16, 7, 0);
    for (int k = 0; k < 70; k++)
      send_item(OP_INSERT, 500 + k, 500, k % 8, 0, 0, 0);
    send_item(OP_QUERY, 520, 500, 0, 400, 0, -1);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 520, 500, 0, 400, 0, -1);
  endtask

  task automatic test_store_full();
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < MAX_POINTS + 2; k++)
      send_item(OP_INSERT, $urandom_range(15000), $urandom_range(11000), $urandom_range(7),
                0, 0, 0);
    send_item(OP_QUERY, 3000, 3000, 0, 600, 0, -1);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int op_pick, sz;
    for (int k = 0; k < count; k++) begin
      op_pick = $urandom_range(99);
      sz = $urandom_range(9) == 0 ? 65535 : $urandom_range(1500);
      if (op_pick < 3) send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      else if (op_pick < 5) send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
      else if (op_pick < 55)
        send_item(OP_INSERT, $urandom_range(12)==0 ? longint'($signed(20'($urandom))) :
                  min_x + $urandom_range(16000), $urandom_range(12)==0 ?
                  longint'($signed(20'($urandom))) : min_y + $urandom_range(12000),
                  $urandom_range(7), $urandom, $urandom, $urandom);
      else
        send_item(OP_QUERY, $urandom_range(12)==0 ? longint'($signed(20'($urandom))) :
                  min_x + $urandom_range(16000), $urandom_range(12)==0 ?
                  longint'($signed(20'($urandom))) : min_y + $urandom_range(12000),
                  $urandom_range(7), sz, $urandom_range(3), int'($signed(4'($urandom))));
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    pcount = 0;
    send_idle = 0;
    recv_stall = 0;
    min_x = 0;
    min_y = 0;
    w_inv = 410;
    h_inv = 410;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_store_full();
    send_idle = 56;
    test_random(100);
    drain_results();
    set_grid(-524288, 524287, 0, 65535);
    send_idle = 0;
    recv_stall = 56;
    test_random(60);
    set_grid(524287, -524288, 65535, 0);
    test_random(40);
    set_grid(-160, 320, 300, 520);
    send_idle = 29;
    recv_stall = 29;
    test_random(100);
    set_grid(0, 0, 410, 410);
    send_idle = 0;
    recv_stall = 0;
    test_random(100);
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
